// ===== hw/rtl/owb_pkg.sv =====
// Shared types, codes and helpers for the one-wire bus master timing engine.
`timescale 1ns / 1ps

package owb_pkg;

	// Command operation codes
	localparam logic [2:0] OP_RESET = 3'd0;
	localparam logic [2:0] OP_WBIT  = 3'd1;
	localparam logic [2:0] OP_RBIT  = 3'd2;
	localparam logic [2:0] OP_WBYTE = 3'd3;
	localparam logic [2:0] OP_RBYTE = 3'd4;

	// Item kind codes
	localparam logic KIND_CMD  = 1'b0;
	localparam logic KIND_TICK = 1'b1;

	// Timing register indexes
	localparam logic [2:0] REG_W1_LOW  = 3'd0;
	localparam logic [2:0] REG_W1_REL  = 3'd1;
	localparam logic [2:0] REG_W0_LOW  = 3'd2;
	localparam logic [2:0] REG_W0_REL  = 3'd3;
	localparam logic [2:0] REG_RD_LOW  = 3'd4;
	localparam logic [2:0] REG_RD_SMP  = 3'd5;
	localparam logic [2:0] REG_RD_TAIL = 3'd6;
	localparam logic [2:0] REG_RST_LOW = 3'd7;

	localparam int NUM_REGS  = 8;
	localparam int US_W      = 10;
	localparam int REG_IDX_W = 3;

	typedef logic [US_W-1:0] us_t;

	localparam us_t PRESENCE_HOLD_US = 10'd240;

	// Register values after reset
	localparam us_t REG_INIT [NUM_REGS] = '{
		10'd8, 10'd40, 10'd55, 10'd2, 10'd4, 10'd12, 10'd30, 10'd500
	};

	// Classified request handed from the front to the back
	typedef struct packed {
		logic       is_tick;
		logic       op_ok;
		logic [2:0] op;
		logic [7:0] data;
		logic       lvl;
	} item_t;

	// Queue status seen by the back
	typedef struct packed {
		logic  valid;
		item_t item;
	} q_head_t;

	// A zero interval counts as one microsecond
	function automatic us_t span_us(input us_t v);
		span_us = (v == '0) ? us_t'(1) : v;
	endfunction

endpackage

// ===== hw/rtl/owb_if.sv =====
// Request and result channel interfaces of the one-wire bus master.
`timescale 1ns / 1ps

interface owb_req_if;
	logic       valid;
	logic       ready;
	logic       kind;
	logic [2:0] op;
	logic [7:0] data;
	logic       line_level;

	modport source (output valid, kind, op, data, line_level, input ready);
	modport sink (input valid, kind, op, data, line_level, output ready);
endinterface

interface owb_res_if;
	logic       valid;
	logic       ready;
	logic       drive_low;
	logic       busy_res;
	logic       done_res;
	logic [7:0] read_value;
	logic       rejected;

	modport source (output valid, drive_low, busy_res, done_res, read_value, rejected,
		input ready);
	modport sink (input valid, drive_low, busy_res, done_res, read_value, rejected,
		output ready);
endinterface

// ===== hw/rtl/one_wire_bus_master_timing.sv =====
// Top level of the one-wire bus master timing engine.
//
//   channel   dir  handshake      payload
//   req_in    in   valid/ready    kind, op, data, line_level
//   res_out   out  valid/ready    drive_low, busy_res, done_res, read_value, rejected
//   cfg       in   cfg_we only    cfg_index (3 b), cfg_data (10 b)
//
// One request per cycle sustained while the result channel is not stalled; a result
// passes through a queue entry and then the result register, in request order.
// The engine state update (counter, shift registers) is the single-cycle loop.
// A two-entry queue and a result register decouple input and output stalls.
// arst_n clears engine state and the queue and loads the default timing values.
`timescale 1ns / 1ps

module one_wire_bus_master_timing (
	input  logic                          clk,
	input  logic                          arst_n,
	owb_req_if.sink                       req_in,
	owb_res_if.source                     res_out,
	input  logic                          cfg_we,
	input  logic [owb_pkg::REG_IDX_W-1:0] cfg_index,
	input  logic [owb_pkg::US_W-1:0]      cfg_data
);

	owb_pkg::q_head_t head;
	logic             pop;

	owb_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_in),
		.head   (head),
		.pop    (pop)
	);

	owb_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.head      (head),
		.pop       (pop),
		.res       (res_out)
	);

endmodule

// ===== hw/rtl/owb_front.sv =====
// Front end: classifies incoming requests and queues them for the engine.
`timescale 1ns / 1ps

module owb_front (
	input  logic             clk,
	input  logic             arst_n,
	owb_req_if.sink          req,
	output owb_pkg::q_head_t head,
	input  logic             pop
);

	owb_pkg::item_t entry_q [2];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     count_q;
	owb_pkg::item_t cls;
	logic           push;

	// Classify the request
	always_comb begin
		cls.is_tick = (req.kind == owb_pkg::KIND_TICK);
		cls.op_ok   = (req.op <= owb_pkg::OP_RBYTE);
		cls.op      = req.op;
		cls.data    = req.data;
		cls.lvl     = req.line_level;
	end

	assign req.ready = (count_q != 2'd2);
	assign push      = req.valid && req.ready;

	assign head.valid = (count_q != 2'd0);
	assign head.item  = entry_q[rd_ptr_q];

	// Two-entry queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= cls;
		end
	end

	// Queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== hw/rtl/owb_back.sv =====
// Back end: bus timing state machine, timing registers and result register.
`timescale 1ns / 1ps

module owb_back (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [owb_pkg::REG_IDX_W-1:0]      cfg_index,
	input  logic [owb_pkg::US_W-1:0]           cfg_data,
	input  owb_pkg::q_head_t                   head,
	output logic                               pop,
	owb_res_if.source                          res
);

	localparam logic [2:0] PH_IDLE      = 3'd0;
	localparam logic [2:0] PH_RST_LOW   = 3'd1;
	localparam logic [2:0] PH_RST_WAIT  = 3'd2;
	localparam logic [2:0] PH_RST_HOLD  = 3'd3;
	localparam logic [2:0] PH_SLOT_LOW  = 3'd4;
	localparam logic [2:0] PH_SLOT_REL  = 3'd5;
	localparam logic [2:0] PH_RD_SAMPLE = 3'd6;
	localparam logic [2:0] PH_RD_TAIL   = 3'd7;

	owb_pkg::us_t regs_q [owb_pkg::NUM_REGS];

	logic [2:0]   phase_q;
	logic [2:0]   op_q;
	owb_pkg::us_t us_q;
	logic [3:0]   bits_q;
	logic [7:0]   tx_q;
	logic [7:0]   rx_q;
	logic         drv_q;

	logic [2:0]   n_phase;
	logic [2:0]   n_op;
	owb_pkg::us_t n_us;
	logic [3:0]   n_bits;
	logic [7:0]   n_tx;
	logic [7:0]   n_rx;
	logic         n_drv;
	logic         n_done;
	logic         n_rej;

	logic         out_valid_q;
	logic         out_drv_q;
	logic         out_busy_q;
	logic         out_done_q;
	logic [7:0]   out_rx_q;
	logic         out_rej_q;

	owb_pkg::item_t it;

	assign it  = head.item;
	assign pop = head.valid && (!out_valid_q || res.ready);

	// Timing registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < owb_pkg::NUM_REGS; i++) begin
				regs_q[i] <= owb_pkg::REG_INIT[i];
			end
		end else if (cfg_we) begin
			regs_q[cfg_index] <= cfg_data;
		end
	end

	// Next state for the request at the queue head
	always_comb begin
		owb_pkg::us_t us_dec;
		logic [3:0]   bits_dec;
		logic [7:0]   tx_nxt;
		logic         rd_new;

		n_phase = phase_q;
		n_op    = op_q;
		n_us    = us_q;
		n_bits  = bits_q;
		n_tx    = tx_q;
		n_rx    = rx_q;
		n_drv   = drv_q;
		n_done  = 1'b0;
		n_rej   = 1'b0;
		us_dec   = us_q - owb_pkg::us_t'(1);
		bits_dec = bits_q - 4'd1;
		tx_nxt   = (phase_q == PH_SLOT_REL) ? {1'b0, tx_q[7:1]} : tx_q;
		rd_new   = (it.op == owb_pkg::OP_RBIT) || (it.op == owb_pkg::OP_RBYTE);

		if (!it.is_tick) begin
			// Command: start a valid operation when idle, or flag it when busy
			if (phase_q != PH_IDLE) begin
				n_rej = 1'b1;
			end else if (it.op_ok) begin
				n_op  = it.op;
				n_drv = 1'b1;
				if (it.op == owb_pkg::OP_RESET) begin
					n_phase = PH_RST_LOW;
					n_us    = owb_pkg::span_us(regs_q[owb_pkg::REG_RST_LOW]);
				end else begin
					n_tx    = it.data;
					n_bits  = ((it.op == owb_pkg::OP_WBYTE) || (it.op == owb_pkg::OP_RBYTE))
						? 4'd8 : 4'd1;
					if (it.op == owb_pkg::OP_RBYTE) begin
						n_rx = 8'd0;
					end
					n_phase = PH_SLOT_LOW;
					if (rd_new) begin
						n_us = owb_pkg::span_us(regs_q[owb_pkg::REG_RD_LOW]);
					end else begin
						n_us = owb_pkg::span_us(it.data[0] ? regs_q[owb_pkg::REG_W1_LOW]
							: regs_q[owb_pkg::REG_W0_LOW]);
					end
				end
			end
		end else if (phase_q == PH_RST_WAIT) begin
			// Presence detect: wait for the slave to pull low
			if (!it.lvl) begin
				n_phase = PH_RST_HOLD;
				n_us    = owb_pkg::span_us(owb_pkg::PRESENCE_HOLD_US);
			end
		end else if (phase_q != PH_IDLE) begin
			// Tick: count down, act on expiry
			n_us = us_dec;
			if (us_dec == '0) begin
				case (phase_q)
					PH_RST_LOW: begin
						n_drv   = 1'b0;
						n_phase = PH_RST_WAIT;
					end
					PH_RST_HOLD: begin
						n_phase = PH_IDLE;
						n_done  = 1'b1;
					end
					PH_SLOT_LOW: begin
						n_drv = 1'b0;
						if ((op_q == owb_pkg::OP_RBIT) || (op_q == owb_pkg::OP_RBYTE)) begin
							n_phase = PH_RD_SAMPLE;
							n_us    = owb_pkg::span_us(regs_q[owb_pkg::REG_RD_SMP]);
						end else begin
							n_phase = PH_SLOT_REL;
							n_us    = owb_pkg::span_us(tx_q[0] ? regs_q[owb_pkg::REG_W1_REL]
								: regs_q[owb_pkg::REG_W0_REL]);
						end
					end
					PH_RD_SAMPLE: begin
						n_rx    = (op_q == owb_pkg::OP_RBIT) ? {7'd0, it.lvl}
							: {it.lvl, rx_q[7:1]};
						n_phase = PH_RD_TAIL;
						n_us    = owb_pkg::span_us(regs_q[owb_pkg::REG_RD_TAIL]);
					end
					PH_SLOT_REL, PH_RD_TAIL: begin
						n_tx   = tx_nxt;
						n_bits = bits_dec;
						if (bits_dec == 4'd0) begin
							n_phase = PH_IDLE;
							n_done  = 1'b1;
						end else begin
							// Open the next bit slot
							n_drv   = 1'b1;
							n_phase = PH_SLOT_LOW;
							if ((op_q == owb_pkg::OP_RBIT) || (op_q == owb_pkg::OP_RBYTE)) begin
								n_us = owb_pkg::span_us(regs_q[owb_pkg::REG_RD_LOW]);
							end else begin
								n_us = owb_pkg::span_us(tx_nxt[0] ? regs_q[owb_pkg::REG_W1_LOW]
									: regs_q[owb_pkg::REG_W0_LOW]);
							end
						end
					end
					default: begin
						n_phase = PH_IDLE;
						n_drv   = 1'b0;
					end
				endcase
			end
		end
	end

	// Engine state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			op_q    <= owb_pkg::OP_RESET;
			us_q    <= '0;
			bits_q  <= 4'd0;
			tx_q    <= 8'd0;
			rx_q    <= 8'd0;
			drv_q   <= 1'b0;
		end else if (pop) begin
			phase_q <= n_phase;
			op_q    <= n_op;
			us_q    <= n_us;
			bits_q  <= n_bits;
			tx_q    <= n_tx;
			rx_q    <= n_rx;
			drv_q   <= n_drv;
		end
	end

	// Result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result register payload
	always_ff @(posedge clk) begin
		if (pop) begin
			out_drv_q  <= n_drv;
			out_busy_q <= (n_phase != PH_IDLE);
			out_done_q <= n_done;
			out_rx_q   <= n_rx;
			out_rej_q  <= n_rej;
		end
	end

	assign res.valid      = out_valid_q;
	assign res.drive_low  = out_drv_q;
	assign res.busy_res   = out_busy_q;
	assign res.done_res   = out_done_q;
	assign res.read_value = out_rx_q;
	assign res.rejected   = out_rej_q;

endmodule

// ===== hw/rtl/owb_checker.sv =====
// Port-level checks for the one-wire bus master timing engine.
`timescale 1ns / 1ps

module owb_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       res_valid,
	input logic       res_ready,
	input logic       drive_low,
	input logic       busy_res,
	input logic       done_res,
	input logic [7:0] read_value,
	input logic       rejected
);

	// A completed operation leaves the engine idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && done_res |-> !busy_res)
		else $error("done reported while still busy");

	// A request is only turned away while an operation runs
	a_rej_busy: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && rejected |-> busy_res && !done_res)
		else $error("rejected without a running operation");

	// The line is only pulled low during an operation
	a_drive_busy: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && drive_low |-> busy_res)
		else $error("line driven while idle");

	// A stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(read_value)
			&& $stable(busy_res) && $stable(drive_low))
		else $error("stalled result changed");

endmodule

bind one_wire_bus_master_timing owb_checker u_owb_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.res_valid  (res_out.valid),
	.res_ready  (res_out.ready),
	.drive_low  (res_out.drive_low),
	.busy_res   (res_out.busy_res),
	.done_res   (res_out.done_res),
	.read_value (res_out.read_value),
	.rejected   (res_out.rejected)
);
